>>> sv/rrpm_pkg.sv
// Package for the read request priority / round robin multiplexer.
// Holds the transaction structs, source tags and address widths.
// Used by rrpm_arb and read_request_priority_rr_mux; depends on nothing.
package rrpm_pkg;

  // Address width used for wrapping and the fixed field widths of a request word.
  localparam int ADDR_WIDTH  = 48;
  localparam int FIELD_AW    = 48;
  localparam int COUNT_W     = 16;
  localparam int REQ_W       = FIELD_AW + COUNT_W;
  localparam int SUM_W       = (ADDR_WIDTH < FIELD_AW) ? ADDR_WIDTH : FIELD_AW;
  localparam int NUM_SRC     = 6;
  localparam int NUM_MEM     = 4;
  localparam int MEM_IDX_W   = $clog2(NUM_MEM);
  localparam int TAG_W       = 3;
  localparam int CFG_IDX_W   = 2;

  // Source tags carried in grant_tag.
  localparam logic [TAG_W-1:0] TAG_DEVICE   = 3'd0;
  localparam logic [TAG_W-1:0] TAG_HOST     = 3'd1;
  localparam logic [TAG_W-1:0] TAG_MEM_BASE = 3'd2;

  // Bit positions of the fixed priority sources in valid_mask.
  localparam int BIT_DEVICE   = 0;
  localparam int BIT_HOST     = 1;
  localparam int BIT_MEM_BASE = 2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_A = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_B = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_C = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_D = 2'd3;

  // Input transaction: the head request of every source.
  typedef struct packed {
    logic [NUM_SRC-1:0] valid_mask;
    logic [REQ_W-1:0]   device_req;
    logic [REQ_W-1:0]   host_req;
    logic [REQ_W-1:0]   mem_a_req;
    logic [REQ_W-1:0]   mem_b_req;
    logic [REQ_W-1:0]   mem_c_req;
    logic [REQ_W-1:0]   mem_d_req;
  } in_item_t;

  // Output transaction: the granted request.
  typedef struct packed {
    logic [TAG_W-1:0]    grant_tag;
    logic [FIELD_AW-1:0] out_addr;
    logic [COUNT_W-1:0]  out_count;
  } out_item_t;

  // Decision of the arbiter for one input transaction.
  typedef struct packed {
    logic                 found;
    logic                 is_mem;
    logic [MEM_IDX_W-1:0] mem_src;
    out_item_t            result;
  } grant_t;

endpackage

>>> sv/read_request_priority_rr_mux.sv
// Top level of the read request arbiter: input register, grant logic, result register.
// Depends on rrpm_pkg and rrpm_arb.
//
// Usage:
//   The input channel (in_valid / in_ready / in_data) carries one transaction with
//   the head request of all six sources and a mask of which are present. The
//   device source wins first, then host, then memory sources A..D round robin.
//   A granted memory request gets its source's offset register added to the
//   address. The output channel (out_valid / out_ready / out_data) carries the
//   granted tag, address and count; a transaction with an empty mask gives no
//   output transaction.
//   Path: the input register feeds the priority search and 48-bit add, whose
//   result is captured by the result register; the grant path is combinational.
//   Throughput: one transaction per cycle while out_ready is high.
//   Stalls: while out_ready is low the result register holds and the input
//   register fills; in_ready drops only when both are full.
//   Reset: both registers empty, offsets zero, round robin pointer at source A so that
//   source B has first pick. Offsets are written through cfg_we, cfg_index and cfg_data
//   while the block is idle; the user must ensure this, the block does not enforce it.
module read_request_priority_rr_mux (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rrpm_pkg::in_item_t                 in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rrpm_pkg::out_item_t                out_data,
  input  logic                               cfg_we,
  input  logic [rrpm_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rrpm_pkg::FIELD_AW-1:0]      cfg_data
);

  logic                                                 stage_valid;
  rrpm_pkg::in_item_t                                   stage_item;
  logic [rrpm_pkg::MEM_IDX_W-1:0]                       last_mem_grant;
  logic [rrpm_pkg::NUM_MEM-1:0][rrpm_pkg::FIELD_AW-1:0] offsets;
  rrpm_pkg::grant_t                                     grant;
  logic                                                 advance;

  // The input register moves on when the result register is free or draining.
  assign advance  = !out_valid || out_ready;
  assign in_ready = !stage_valid || advance;

  // Offset registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      offsets <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rrpm_pkg::REG_OFFSET_A: offsets[0] <= cfg_data;
        rrpm_pkg::REG_OFFSET_B: offsets[1] <= cfg_data;
        rrpm_pkg::REG_OFFSET_C: offsets[2] <= cfg_data;
        rrpm_pkg::REG_OFFSET_D: offsets[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (in_ready) begin
      stage_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_item <= in_data;
    end
  end

  // Grant decision for the registered transaction.
  rrpm_arb u_arb (
    .item           (stage_item),
    .last_mem_grant (last_mem_grant),
    .offsets        (offsets),
    .grant          (grant)
  );

  // Round robin pointer moves only on a memory grant.
  always_ff @(posedge clk) begin
    if (rst) begin
      last_mem_grant <= '0;
    end else if (stage_valid && advance && grant.found && grant.is_mem) begin
      last_mem_grant <= grant.mem_src;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_valid && grant.found;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid && grant.found) begin
      out_data <= grant.result;
    end
  end

endmodule

>>> sv/rrpm_arb.sv
// Grant logic: fixed priority for device and host, round robin over memory sources.
// Also adds the memory source offset to the granted address.
// Depends on rrpm_pkg.
module rrpm_arb (
  input  rrpm_pkg::in_item_t                                   item,
  input  logic [rrpm_pkg::MEM_IDX_W-1:0]                       last_mem_grant,
  input  logic [rrpm_pkg::NUM_MEM-1:0][rrpm_pkg::FIELD_AW-1:0] offsets,
  output rrpm_pkg::grant_t                                     grant
);

  logic [rrpm_pkg::NUM_MEM-1:0][rrpm_pkg::REQ_W-1:0] mem_word;

  // Memory request words in source order, so the round robin can index them.
  assign mem_word[0] = item.mem_a_req;
  assign mem_word[1] = item.mem_b_req;
  assign mem_word[2] = item.mem_c_req;
  assign mem_word[3] = item.mem_d_req;

  // Pick the winner, then form the wrapped address and copy the count.
  always_comb begin
    logic [rrpm_pkg::MEM_IDX_W-1:0] src;
    logic [rrpm_pkg::REQ_W-1:0]     word;
    logic [rrpm_pkg::SUM_W-1:0]     base;
    logic [rrpm_pkg::SUM_W-1:0]     off;
    logic [rrpm_pkg::SUM_W-1:0]     sum;
    logic [rrpm_pkg::TAG_W-1:0]     tag;
    logic                           found;
    logic                           is_mem;
    logic [rrpm_pkg::MEM_IDX_W-1:0] mem_src;

    found   = 1'b0;
    is_mem  = 1'b0;
    mem_src = last_mem_grant;
    tag     = rrpm_pkg::TAG_DEVICE;
    word    = '0;
    off     = '0;
    src     = '0;

    priority if (item.valid_mask[rrpm_pkg::BIT_DEVICE]) begin
      found = 1'b1;
      tag   = rrpm_pkg::TAG_DEVICE;
      word  = item.device_req;
    end else if (item.valid_mask[rrpm_pkg::BIT_HOST]) begin
      found = 1'b1;
      tag   = rrpm_pkg::TAG_HOST;
      word  = item.host_req;
    end else begin
      // Search starts with the source after the last memory grant.
      for (int k = 1; k <= rrpm_pkg::NUM_MEM; k++) begin
        src = last_mem_grant + rrpm_pkg::MEM_IDX_W'(k);
        if (!found && item.valid_mask[rrpm_pkg::BIT_MEM_BASE + int'(src)]) begin
          found   = 1'b1;
          is_mem  = 1'b1;
          mem_src = src;
        end
      end
      if (found) begin
        tag  = rrpm_pkg::TAG_MEM_BASE + rrpm_pkg::TAG_W'(mem_src);
        word = mem_word[mem_src];
        off  = offsets[mem_src][rrpm_pkg::SUM_W-1:0];
      end
    end

    // The sum wraps at the address width.
    base = word[rrpm_pkg::SUM_W-1:0];
    sum  = base + off;

    grant.found            = found;
    grant.is_mem           = is_mem;
    grant.mem_src          = mem_src;
    grant.result.grant_tag = tag;
    grant.result.out_addr  = rrpm_pkg::FIELD_AW'(sum);
    grant.result.out_count = word[rrpm_pkg::REQ_W-1:rrpm_pkg::FIELD_AW];
  end

endmodule

>>> sim/read_request_priority_rr_mux_tb.sv
// Self-checking testbench for the read request arbiter read_request_priority_rr_mux.
// Predicts every grant (fixed priority, then round robin with per-source offsets)
// and checks it. Depends on rrpm_pkg and the RTL of the block only.
module read_request_priority_rr_mux_tb;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int SETTLE_CYCLES = 6;
  localparam int PHASE_ITEMS = 460;
  localparam logic [63:0] ADDR_MASK =
    (rrpm_pkg::ADDR_WIDTH >= 64) ? {64{1'b1}}
                                 : ((64'd1 << rrpm_pkg::ADDR_WIDTH) - 64'd1);
  localparam logic [rrpm_pkg::FIELD_AW-1:0] OFFSET_MAX = {rrpm_pkg::FIELD_AW{1'b1}};

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  rrpm_pkg::in_item_t             in_data;
  logic                           out_valid;
  logic                           out_ready;
  rrpm_pkg::out_item_t            out_data;
  logic                           cfg_we;
  logic [rrpm_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rrpm_pkg::FIELD_AW-1:0]  cfg_data;

  // When set, neither side inserts gaps or stalls.
  bit calm;
  int cycles;

  // Mirror of the arbiter: offsets, round robin pointer and the grants still to come.
  class grant_checker;
    logic [rrpm_pkg::FIELD_AW-1:0]  offsets [rrpm_pkg::NUM_MEM];
    logic [rrpm_pkg::MEM_IDX_W-1:0] last_mem;
    rrpm_pkg::out_item_t            expected_grants [$];
    int                             mismatches;

    function new();
      foreach (offsets[i]) offsets[i] = '0;
      last_mem = '0;
      mismatches = 0;
    endfunction

    function void set_offset(logic [rrpm_pkg::CFG_IDX_W-1:0] idx,
                             logic [rrpm_pkg::FIELD_AW-1:0] value);
      offsets[idx] = value;
    endfunction

    function int pending();
      return expected_grants.size();
    endfunction

    task report_mismatch(string what);
      $display("mismatch at %0t: %s", $time, what);
      mismatches++;
    endtask

    // Works out the grant for one transaction and moves the pointer on a memory grant.
    function bit predict_grant(rrpm_pkg::in_item_t it, output rrpm_pkg::out_item_t g);
      logic [rrpm_pkg::REQ_W-1:0]     words [rrpm_pkg::NUM_SRC];
      logic [rrpm_pkg::REQ_W-1:0]     word;
      logic [63:0]                    sum;
      logic [rrpm_pkg::MEM_IDX_W-1:0] src;
      bit                             hit;
      words[rrpm_pkg::BIT_DEVICE]     = it.device_req;
      words[rrpm_pkg::BIT_HOST]       = it.host_req;
      words[rrpm_pkg::BIT_MEM_BASE]   = it.mem_a_req;
      words[rrpm_pkg::BIT_MEM_BASE+1] = it.mem_b_req;
      words[rrpm_pkg::BIT_MEM_BASE+2] = it.mem_c_req;
      words[rrpm_pkg::BIT_MEM_BASE+3] = it.mem_d_req;
      g = '0;
      word = '0;
      sum = '0;
      hit = 0;
      if (it.valid_mask[rrpm_pkg::BIT_DEVICE]) begin
        hit = 1;
        g.grant_tag = rrpm_pkg::TAG_DEVICE;
        word = words[rrpm_pkg::BIT_DEVICE];
        sum = 64'(word[rrpm_pkg::FIELD_AW-1:0]) & ADDR_MASK;
      end else if (it.valid_mask[rrpm_pkg::BIT_HOST]) begin
        hit = 1;
        g.grant_tag = rrpm_pkg::TAG_HOST;
        word = words[rrpm_pkg::BIT_HOST];
        sum = 64'(word[rrpm_pkg::FIELD_AW-1:0]) & ADDR_MASK;
      end else begin
        // Search starts with the memory source after the last one granted.
        for (int k = 1; k <= rrpm_pkg::NUM_MEM; k++) begin
          src = last_mem + rrpm_pkg::MEM_IDX_W'(k);
          if (!hit && it.valid_mask[rrpm_pkg::BIT_MEM_BASE + src]) begin
            hit = 1;
            g.grant_tag = rrpm_pkg::TAG_MEM_BASE + rrpm_pkg::TAG_W'(src);
            word = words[rrpm_pkg::BIT_MEM_BASE + src];
            sum = ((64'(word[rrpm_pkg::FIELD_AW-1:0]) & ADDR_MASK)
                   + (64'(offsets[src]) & ADDR_MASK)) & ADDR_MASK;
            last_mem = src;
          end
        end
      end
      g.out_addr = sum[rrpm_pkg::FIELD_AW-1:0];
      g.out_count = word[rrpm_pkg::REQ_W-1:rrpm_pkg::FIELD_AW];
      return hit;
    endfunction

    function void note_request(rrpm_pkg::in_item_t it);
      rrpm_pkg::out_item_t g;
      if (predict_grant(it, g)) expected_grants.push_back(g);
    endfunction

    task check_grant(rrpm_pkg::out_item_t got);
      rrpm_pkg::out_item_t want;
      if (expected_grants.size() == 0) begin
        report_mismatch($sformatf("unexpected grant, tag %0d", got.grant_tag));
        return;
      end
      want = expected_grants.pop_front();
      if (got.grant_tag !== want.grant_tag)
        report_mismatch($sformatf("grant_tag %0d, expected %0d", got.grant_tag,
                                  want.grant_tag));
      if (got.out_addr !== want.out_addr)
        report_mismatch($sformatf("out_addr %h, expected %h", got.out_addr,
                                  want.out_addr));
      if (got.out_count !== want.out_count)
        report_mismatch($sformatf("out_count %h, expected %h", got.out_count,
                                  want.out_count));
    endtask
  endclass

  grant_checker grants;

  read_request_priority_rr_mux u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Gap length: mostly none, sometimes short, rarely long.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [rrpm_pkg::REQ_W-1:0] rand_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return {{rrpm_pkg::COUNT_W{1'b1}}, {rrpm_pkg::FIELD_AW{1'b0}}};
      3: return {{rrpm_pkg::COUNT_W{1'b0}}, {rrpm_pkg::FIELD_AW{1'b1}}};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [rrpm_pkg::FIELD_AW-1:0] rand_offset();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return OFFSET_MAX;
      default: return rrpm_pkg::FIELD_AW'({$urandom, $urandom});
    endcase
  endfunction

  // Word kind: 0 random, 1 all ones, 2 all zeros.
  function automatic rrpm_pkg::in_item_t make_item(logic [rrpm_pkg::NUM_SRC-1:0] mask,
                                                   int kind);
    rrpm_pkg::in_item_t it;
    it.valid_mask = mask;
    it.device_req = rand_word();
    it.host_req   = rand_word();
    it.mem_a_req  = rand_word();
    it.mem_b_req  = rand_word();
    it.mem_c_req  = rand_word();
    it.mem_d_req  = rand_word();
    if (kind == 1) begin
      it = {mask, {(rrpm_pkg::NUM_SRC*rrpm_pkg::REQ_W){1'b1}}};
    end else if (kind == 2) begin
      it = {mask, {(rrpm_pkg::NUM_SRC*rrpm_pkg::REQ_W){1'b0}}};
    end
    return it;
  endfunction

  // Mostly memory-only masks so that the round robin gets a thorough workout.
  function automatic logic [rrpm_pkg::NUM_SRC-1:0] rand_mask();
    int r;
    r = $urandom_range(0, 99);
    if (r < 8) return '0;
    if (r < 60) return {4'($urandom_range(0, 15)), 2'b00};
    return rrpm_pkg::NUM_SRC'($urandom_range(0, 63));
  endfunction

  // Presents one transaction, waits for acceptance, then idles for a random gap.
  task automatic send_item(rrpm_pkg::in_item_t it);
    int gap;
    @(negedge clk);
    in_valid = 1'b1;
    in_data = it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    grants.note_request(it);
    gap = pick_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_data = make_item(rand_mask(), 0);
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  // Waits until every grant has come back and the pipeline has emptied.
  task automatic drain();
    @(negedge clk);
    in_valid = 1'b0;
    while (grants.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_offset(logic [rrpm_pkg::CFG_IDX_W-1:0] idx,
                              logic [rrpm_pkg::FIELD_AW-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    grants.set_offset(idx, value);
  endtask

  task automatic write_offsets(logic [rrpm_pkg::FIELD_AW-1:0] a,
                               logic [rrpm_pkg::FIELD_AW-1:0] b,
                               logic [rrpm_pkg::FIELD_AW-1:0] c,
                               logic [rrpm_pkg::FIELD_AW-1:0] d);
    write_offset(rrpm_pkg::REG_OFFSET_A, a);
    write_offset(rrpm_pkg::REG_OFFSET_B, b);
    write_offset(rrpm_pkg::REG_OFFSET_C, c);
    write_offset(rrpm_pkg::REG_OFFSET_D, d);
  endtask

  // Directed transactions with the reset offsets.
  task automatic run_directed();
    send_item(make_item(6'h00, 0));   // no request at all
    send_item(make_item(6'h01, 1));   // device alone, extreme words
    send_item(make_item(6'h02, 2));   // host alone, zero words
    send_item(make_item(6'h03, 0));   // device beats host
    send_item(make_item(6'h3F, 1));   // everyone requests
    // Full memory contention: B first after reset, then C, D, A.
    repeat (4) send_item(make_item(6'h3C, 0));
    send_item(make_item(6'h3E, 0));   // host grant leaves the pointer alone
    send_item(make_item(6'h3C, 0));
    send_item(make_item(6'h04, 2));
    send_item(make_item(6'h08, 0));
    send_item(make_item(6'h10, 0));
    send_item(make_item(6'h20, 1));
    send_item(make_item(6'h24, 0));   // pointer wraps from D round to A
    send_item(make_item(6'h3D, 0));
    send_item(make_item(6'h30, 0));
    send_item(make_item(6'h00, 1));
  endtask

  // Ready side: a cycle of ready, then a stall of random length.
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold > 0) begin
        out_ready = 1'b0;
        hold--;
      end else begin
        out_ready = 1'b1;
        hold = pick_gap();
      end
    end
  end

  // Every accepted output transaction is checked against the oldest prediction.
  initial begin
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) grants.check_grant(out_data);
    end
  end

  // Watchdog on the total run length.
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // Main sequence: reset, directed part, then random phases under several offset settings.
  initial begin
    grants = new();
    rst = 1'b1;
    calm = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = rrpm_pkg::REG_OFFSET_A;
    cfg_data = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    run_directed();
    drain();

    // Largest offsets with the largest addresses make every sum wrap.
    write_offsets(OFFSET_MAX, OFFSET_MAX, OFFSET_MAX, OFFSET_MAX);
    send_item(make_item(6'h04, 1));
    send_item(make_item(6'h08, 1));
    send_item(make_item(6'h10, 1));
    send_item(make_item(6'h20, 1));

    for (int phase = 0; phase < 4; phase++) begin
      drain();
      case (phase)
        0: write_offsets(OFFSET_MAX, '0, 48'd1, rand_offset());
        1: write_offsets(rand_offset(), rand_offset(), rand_offset(), rand_offset());
        2: write_offsets('0, rand_offset(), OFFSET_MAX, 48'd1);
        default: write_offsets(rand_offset(), OFFSET_MAX, '0, OFFSET_MAX);
      endcase
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        calm = ((n / 115) % 4 == 3);
        send_item(make_item(rand_mask(), 0));
      end
      calm = 1'b0;
    end

    drain();
    if (grants.pending() != 0) grants.report_mismatch("grants never arrived");
    if (grants.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
